/* hw/rtl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the three-axis spring-damper stepper.
// ----------------------------------------------------------------------------
package msd_pkg;

   localparam int unsigned POS_W  = 32;   // Q8.24 positions and drive terms
   localparam int unsigned COEF_W = 32;   // Q2.30 coefficients
   localparam int unsigned ADDR_W = 3;

   // register indexes on the csr port
   typedef enum logic [ADDR_W-1:0] {
      REG_COEF_A_RELAXED = 3'd0,
      REG_COEF_B_RELAXED = 3'd1,
      REG_COEF_A_DRIVEN  = 3'd2,
      REG_COEF_B_DRIVEN  = 3'd3,
      REG_DRIVE_X        = 3'd4,
      REG_DRIVE_Y        = 3'd5,
      REG_DRIVE_Z        = 3'd6
   } reg_index_type;

   localparam logic [COEF_W-1:0] COEF_A_RELAXED_RST = 32'd2028179001;
   localparam logic [COEF_W-1:0] COEF_B_RELAXED_RST = 32'd978298106;
   localparam logic [COEF_W-1:0] COEF_A_DRIVEN_RST  = 32'd1837291566;
   localparam logic [COEF_W-1:0] COEF_B_DRIVEN_RST  = 32'd787410671;
   localparam logic [POS_W-1:0]  DRIVE_X_RST        = 32'd0;
   localparam logic [POS_W-1:0]  DRIVE_Y_RST        = 32'd372827;
   localparam logic [POS_W-1:0]  DRIVE_Z_RST        = 32'd0;

   // coefficients and drive terms chosen for the item in the work stage
   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [POS_W-1:0]  drive_x;
      logic signed [POS_W-1:0]  drive_y;
      logic signed [POS_W-1:0]  drive_z;
      logic                     driven;
   } step_ctrl_type;

endpackage

/* hw/rtl/msd_csr.sv */
// ----------------------------------------------------------------------------
// msd_csr
// Coefficient and drive registers, and per-tick coefficient pair selection.
// ----------------------------------------------------------------------------
module msd_csr
   import msd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [31:0]         wr_data,
   input  logic                force_on,
   output step_ctrl_type       ctrl
);

   logic [COEF_W-1:0] coef_a_rel_ff, coef_b_rel_ff, coef_a_drv_ff, coef_b_drv_ff;
   logic [POS_W-1:0]  drive_x_ff, drive_y_ff, drive_z_ff;
   logic              any_drive;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_rel_ff <= COEF_A_RELAXED_RST;
         coef_b_rel_ff <= COEF_B_RELAXED_RST;
         coef_a_drv_ff <= COEF_A_DRIVEN_RST;
         coef_b_drv_ff <= COEF_B_DRIVEN_RST;
         drive_x_ff    <= DRIVE_X_RST;
         drive_y_ff    <= DRIVE_Y_RST;
         drive_z_ff    <= DRIVE_Z_RST;
      end else if (wr_en) begin
         case (wr_addr)
            REG_COEF_A_RELAXED: coef_a_rel_ff <= wr_data;
            REG_COEF_B_RELAXED: coef_b_rel_ff <= wr_data;
            REG_COEF_A_DRIVEN:  coef_a_drv_ff <= wr_data;
            REG_COEF_B_DRIVEN:  coef_b_drv_ff <= wr_data;
            REG_DRIVE_X:        drive_x_ff    <= wr_data;
            REG_DRIVE_Y:        drive_y_ff    <= wr_data;
            REG_DRIVE_Z:        drive_z_ff    <= wr_data;
            default: ;          // unmapped index: dropped
         endcase
      end
   end

   assign any_drive = (drive_x_ff != '0) || (drive_y_ff != '0) || (drive_z_ff != '0);

   always_comb begin
      ctrl.driven  = force_on && any_drive;
      ctrl.coef_a  = ctrl.driven ? coef_a_drv_ff : coef_a_rel_ff;
      ctrl.coef_b  = ctrl.driven ? coef_b_drv_ff : coef_b_rel_ff;
      // drive terms only count while the force is held
      ctrl.drive_x = force_on ? drive_x_ff : '0;
      ctrl.drive_y = force_on ? drive_y_ff : '0;
      ctrl.drive_z = force_on ? drive_z_ff : '0;
   end

endmodule

/* hw/rtl/msd_axis.sv */
// ----------------------------------------------------------------------------
// msd_axis
// One axis: holds current/previous position, computes a*cur - b*prev + drive.
// ----------------------------------------------------------------------------
module msd_axis
   import msd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic signed [COEF_W-1:0] coef_a,
   input  logic signed [COEF_W-1:0] coef_b,
   input  logic signed [POS_W-1:0]  drive,
   output logic signed [POS_W-1:0]  next_pos,
   output logic                     sat
);

   localparam logic signed [64:0] HALF_LSB = 65'sh0_2000_0000;  // 2^29

   logic signed [POS_W-1:0] cur_ff, prev_ff;
   logic signed [63:0]      prod_a, prod_b;
   logic signed [64:0]      acc, acc_rnd;
   logic signed [34:0]      scaled;
   logic signed [35:0]      sum;

   // exact Q.54 products, 65-bit difference cannot wrap
   assign prod_a  = coef_a * cur_ff;
   assign prod_b  = coef_b * prev_ff;
   assign acc     = $signed({prod_a[63], prod_a}) - $signed({prod_b[63], prod_b});
   assign acc_rnd = acc + HALF_LSB;
   assign scaled  = acc_rnd[64:30];      // floor shift to Q.24
   assign sum     = $signed({scaled[34], scaled}) + $signed({{4{drive[31]}}, drive});

   always_comb begin
      sat      = (sum[35:31] != 5'b00000) && (sum[35:31] != 5'b11111);
      next_pos = sum[31:0];
      if (sat) begin
         next_pos = sum[35] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         prev_ff <= '0;
      end else if (advance) begin
         prev_ff <= cur_ff;
         cur_ff  <= next_pos;
      end
   end

endmodule

/* hw/rtl/mass_spring_damper_step.sv */
// ----------------------------------------------------------------------------
// mass_spring_damper_step
// Three-axis spring-damper tick stepper, Q8.24 positions, Q2.30 coefficients.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  req      in         req_tvalid / req_tready   tdata[0] force_on
//  rsp      out        rsp_tvalid / rsp_tready   tdata x,y,z; tuser mode, sat
//  csr      in         csr_valid  / csr_ready    csr_addr index, csr_wdata
//
//  One item per clock sustained while rsp_tready is high. An accepted item sits
//  in the input register, the axis datapath (two 32x32 multiplies per axis,
//  round, add, clip) works on it there and the result lands in the output
//  register. Position state moves on with each result.
//  Synchronous reset clears the stages, positions and registers to defaults.
//  A stalled rsp holds the result; the input register still takes an item and
//  req_tready drops only when both stages are full and rsp_tready is low.
//  csr is always ready; write only while no item is in flight.
// ----------------------------------------------------------------------------
module mass_spring_damper_step
   import msd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request: bit 0 force_on, bits 7:1 zero
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   // response: [31:0] out_x, [63:32] out_y, [95:64] out_z
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [3*POS_W-1:0] rsp_tdata,
   // response flags: [0] driven_mode, [1] saturated
   output logic [1:0]         rsp_tuser,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ADDR_W-1:0]  csr_addr,
   input  logic [31:0]        csr_wdata
);

   logic                    in_valid_ff, in_valid_in;
   logic                    force_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [3*POS_W-1:0]      out_data_ff;
   logic [1:0]              out_user_ff;
   logic                    fire;        // work stage produces a result this cycle
   logic                    req_take;
   step_ctrl_type           ctrl;
   logic signed [POS_W-1:0] nx, ny, nz;
   logic                    sx, sy, sz;

   assign csr_ready  = 1'b1;
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   msd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_addr  (csr_addr),
      .wr_data  (csr_wdata),
      .force_on (force_ff),
      .ctrl     (ctrl)
   );

   msd_axis u_axis_x (
      .clock (clock), .reset (reset), .advance (fire),
      .coef_a (ctrl.coef_a), .coef_b (ctrl.coef_b), .drive (ctrl.drive_x),
      .next_pos (nx), .sat (sx)
   );

   msd_axis u_axis_y (
      .clock (clock), .reset (reset), .advance (fire),
      .coef_a (ctrl.coef_a), .coef_b (ctrl.coef_b), .drive (ctrl.drive_y),
      .next_pos (ny), .sat (sy)
   );

   msd_axis u_axis_z (
      .clock (clock), .reset (reset), .advance (fire),
      .coef_a (ctrl.coef_a), .coef_b (ctrl.coef_b), .drive (ctrl.drive_z),
      .next_pos (nz), .sat (sz)
   );

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         force_ff <= req_tdata[0];
      end
      if (fire) begin
         out_data_ff <= {nz, ny, nx};
         out_user_ff <= {sx || sy || sz, ctrl.driven};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

/* tb/msd_tick_check_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msd_tick_check_pkg
// Scoreboard for the spring-damper stepper. It keeps its own copy of the
// coefficient and drive registers and of the axis positions. It predicts one
// result per accepted tick and checks the block's results in order.
// ----------------------------------------------------------------------------
package msd_tick_check_pkg;
   import msd_pkg::*;

   class msd_tick_scoreboard;
      typedef struct {
         logic [POS_W-1:0] pos [3];
         logic             driven;
         logic             sat;
      } tick_result_type;

      localparam logic signed [67:0] ROUND_HALF = 68'sd536870912;   // 2^29
      localparam logic signed [67:0] POS_MAX    = 68'sd2147483647;
      localparam logic signed [67:0] POS_MIN    = -68'sd2147483648;

      logic signed [COEF_W-1:0] coef_a_rel, coef_b_rel, coef_a_drv, coef_b_drv;
      logic signed [POS_W-1:0]  drive [3];
      logic signed [POS_W-1:0]  pos_cur [3];
      logic signed [POS_W-1:0]  pos_prev [3];
      tick_result_type          expected_ticks [$];
      int unsigned              errors;
      int unsigned              ticks_checked;

      function new();
         coef_a_rel = COEF_A_RELAXED_RST;
         coef_b_rel = COEF_B_RELAXED_RST;
         coef_a_drv = COEF_A_DRIVEN_RST;
         coef_b_drv = COEF_B_DRIVEN_RST;
         drive[0]   = DRIVE_X_RST;
         drive[1]   = DRIVE_Y_RST;
         drive[2]   = DRIVE_Z_RST;
         for (int k = 0; k < 3; k++) begin
            pos_cur[k]  = '0;
            pos_prev[k] = '0;
         end
         errors        = 0;
         ticks_checked = 0;
      endfunction

      // out-of-range indexes fall through and change nothing
      function void write_reg(logic [ADDR_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_COEF_A_RELAXED: coef_a_rel = val;
            REG_COEF_B_RELAXED: coef_b_rel = val;
            REG_COEF_A_DRIVEN:  coef_a_drv = val;
            REG_COEF_B_DRIVEN:  coef_b_drv = val;
            REG_DRIVE_X:        drive[0]   = val;
            REG_DRIVE_Y:        drive[1]   = val;
            REG_DRIVE_Z:        drive[2]   = val;
            default: ;
         endcase
      endfunction

      // one tick: next = round(a*cur - b*prev) + drive, clipped to 32 bits
      function void note_tick(logic force_on);
         logic                     driven;
         logic signed [COEF_W-1:0] a, b;
         logic signed [67:0]       a_w, b_w, cur_w, prev_w, drv_w, acc, q;
         tick_result_type          r;
         driven = force_on && (drive[0] != 0 || drive[1] != 0 || drive[2] != 0);
         a = driven ? coef_a_drv : coef_a_rel;
         b = driven ? coef_b_drv : coef_b_rel;
         a_w = a;
         b_w = b;
         r.driven = driven;
         r.sat    = 1'b0;
         for (int k = 0; k < 3; k++) begin
            cur_w  = pos_cur[k];
            prev_w = pos_prev[k];
            drv_w  = 0;
            if (force_on)
               drv_w = drive[k];
            acc = a_w * cur_w - b_w * prev_w;
            q   = ((acc + ROUND_HALF) >>> 30) + drv_w;
            if (q > POS_MAX) begin
               q     = POS_MAX;
               r.sat = 1'b1;
            end
            if (q < POS_MIN) begin
               q     = POS_MIN;
               r.sat = 1'b1;
            end
            pos_prev[k] = pos_cur[k];
            pos_cur[k]  = q[31:0];
            r.pos[k]    = q[31:0];
         end
         expected_ticks.push_back(r);
      endfunction

      function void check_result(logic [3*POS_W-1:0] data, logic [1:0] flags);
         tick_result_type  want;
         logic [POS_W-1:0] got [3];
         logic             bad;
         for (int k = 0; k < 3; k++)
            got[k] = data[k*POS_W +: POS_W];
         if (expected_ticks.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result with no tick pending: x=%h y=%h z=%h mode=%b sat=%b",
                        $time, got[0], got[1], got[2], flags[0], flags[1]);
            return;
         end
         want = expected_ticks.pop_front();
         bad  = (flags[0] !== want.driven) || (flags[1] !== want.sat);
         for (int k = 0; k < 3; k++)
            if (got[k] !== want.pos[k])
               bad = 1'b1;
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: tick %0d mismatch", $time, ticks_checked);
               $display("   expected x=%h y=%h z=%h mode=%b sat=%b",
                        want.pos[0], want.pos[1], want.pos[2], want.driven, want.sat);
               $display("   actual   x=%h y=%h z=%h mode=%b sat=%b",
                        got[0], got[1], got[2], flags[0], flags[1]);
            end
         end
         ticks_checked++;
      endfunction

      function int pending();
         return expected_ticks.size();
      endfunction
   endclass

endpackage

/* tb/tb_mass_spring_damper_step.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mass_spring_damper_step
// Self-checking bench for the three-axis spring-damper stepper. A directed
// opening covers reset values, force on and off, the relaxed pair with zero
// drives, saturation both ways, ignored register writes and half-up rounding.
// Random phases then load fresh register settings and send runs of ticks,
// with random gaps on the request side and random stalls on the response.
// ----------------------------------------------------------------------------
module tb_mass_spring_damper_step;
   import msd_pkg::*;
   import msd_tick_check_pkg::*;

   localparam logic [ADDR_W-1:0] REG_OUT_OF_RANGE = 3'd7;  // no register here
   localparam int unsigned       STALL_LIMIT      = 2000;  // cycles with no handshake
   localparam int unsigned       PHASE_TICKS      = 100;
   localparam int unsigned       RANDOM_PHASES    = 9;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [3*POS_W-1:0] rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [ADDR_W-1:0]  csr_addr   = REG_COEF_A_RELAXED;
   logic [31:0]        csr_wdata  = '0;

   msd_tick_scoreboard sb;
   int unsigned        idle_pct   = 33;   // share of cycles each side sits idle
   int unsigned        quiet_cycles = 0;

   always #5 clock = ~clock;

   mass_spring_damper_step i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [0] force_on, [7:1] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [31:0] out_x, [63:32] out_y, [95:64] out_z
      .rsp_tuser  (rsp_tuser),     // [0] driven_mode, [1] saturated
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---- response side: random back-pressure, checked at the rising edge ----
   always @(negedge clock)
      rsp_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);

   // ---- watchdog: any handshake counts as progress ----
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL mass_spring_damper_step");
         $finish;
      end
   end

   // ---- register writes: valid stays up across a batch, dropped at the end ----
   task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [31:0] a_rel, b_rel, a_drv, b_drv,
                                input logic [31:0] dx, dy, dz, input logic poke_unused);
      write_reg(REG_COEF_A_RELAXED, a_rel);
      write_reg(REG_COEF_B_RELAXED, b_rel);
      write_reg(REG_COEF_A_DRIVEN,  a_drv);
      write_reg(REG_COEF_B_DRIVEN,  b_drv);
      write_reg(REG_DRIVE_X,        dx);
      write_reg(REG_DRIVE_Y,        dy);
      write_reg(REG_DRIVE_Z,        dz);
      // a write to the unused index must leave everything alone
      if (poke_unused)
         write_reg(REG_OUT_OF_RANGE, $urandom);
      csr_release();
   endtask

   // ---- tick items: optional gap first, then hold valid until taken ----
   task automatic send_tick(input logic force_on);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1)) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, force_on};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(force_on);
   endtask

   // stop sending and wait until every predicted result has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [31:0] small_signed(input int unsigned span);
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic load_random_settings(input int unsigned kind);
      logic [31:0] w [7];
      case (kind)
         0: begin
            // lightly damped, close to the reset values; some drives zero
            w[0] = $urandom_range(2093796556, 1717986918);
            w[1] = $urandom_range(1052266987, 644245094);
            w[2] = $urandom_range(2093796556, 1717986918);
            w[3] = $urandom_range(1052266987, 644245094);
            for (int k = 4; k < 7; k++)
               w[k] = ($urandom_range(3) == 0) ? 32'h0 : small_signed(1 << 20);
         end
         1: begin
            for (int k = 0; k < 7; k++)
               w[k] = $urandom;
         end
         2: begin
            // strongly damped: pulls saturated positions back toward zero
            for (int k = 0; k < 4; k++)
               w[k] = small_signed(1 << 28);
            for (int k = 4; k < 7; k++)
               w[k] = ($urandom_range(1) == 0) ? 32'h0 : small_signed(1 << 16);
         end
         default: begin
            for (int k = 0; k < 7; k++)
               case ($urandom_range(5))
                  0:       w[k] = 32'h8000_0000;
                  1:       w[k] = 32'h7FFF_FFFF;
                  2:       w[k] = 32'h0;
                  3:       w[k] = 32'hFFFF_FFFF;
                  4:       w[k] = 32'h1;
                  default: w[k] = $urandom;
               endcase
         end
      endcase
      load_settings(w[0], w[1], w[2], w[3], w[4], w[5], w[6], $urandom_range(3) == 0);
   endtask

   initial begin
      int unsigned left, run_len;
      logic        level;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: only drive_y is set, so force on selects the driven pair
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();

      // all drives zero: force on still uses the relaxed pair
      load_settings(COEF_A_RELAXED_RST, COEF_B_RELAXED_RST, COEF_A_DRIVEN_RST,
                    COEF_B_DRIVEN_RST, 32'h0, 32'h0, 32'h0, 1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();

      // extreme driven pair and drives: x clips high, y clips low
      load_settings(COEF_A_RELAXED_RST, COEF_B_RELAXED_RST, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
      repeat (5) send_tick(1'b1);
      drain();

      // extreme relaxed pair on the clipped positions
      load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
      repeat (4) send_tick(1'b0);
      drain();

      // zero coefficients bring every axis back to rest
      load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      repeat (2) send_tick(1'b0);
      drain();

      // a = 0.5 on +1 and -1: rounding ties go up
      load_settings(32'h0, 32'h0, 32'h2000_0000, 32'h0, 32'h0000_0001,
                    32'hFFFF_FFFF, 32'h0, 1'b0);
      repeat (3) send_tick(1'b1);
      drain();

      // random phases; one runs with no idling on either side
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_pct = (ph == 4) ? 0 : 33;
         load_random_settings(ph % 4);
         left = PHASE_TICKS;
         while (left != 0) begin
            run_len = $urandom_range(12, 1);
            if (run_len > left)
               run_len = left;
            level = $urandom_range(1);
            repeat (run_len) send_tick(level);
            left -= run_len;
         end
         drain();
      end

      idle_pct = 33;
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS mass_spring_damper_step");
      else
         $display("FAIL mass_spring_damper_step");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/msd_pkg.sv
hw/rtl/msd_csr.sv
hw/rtl/msd_axis.sv
hw/rtl/mass_spring_damper_step.sv
tb/msd_tick_check_pkg.sv
tb/tb_mass_spring_damper_step.sv
